@@ sv/nearest_point_on_box_macros.svh @@
// Assertion macros shared by the nearest_point_on_box RTL
`ifndef NEAREST_POINT_ON_BOX_MACROS_SVH
`define NEAREST_POINT_ON_BOX_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define NPB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked after the delay given by n
`define NPB_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ sv/npb_pkg.sv @@
// Shared constants and types for the nearest-point-on-box pipeline
package npb_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS       = 12;
    localparam int BOX_MAX_RESET   = 1 << FRAC_BITS;
    localparam int NUM_AXES        = 3;
    localparam int AXIS_WIDTH      = 2;
    localparam int FACE_WIDTH      = 4;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic signed [FACE_WIDTH-1:0] FACE_MISS = '1;

    // Per-stage control that travels with the data
    typedef struct packed {
        logic valid;
        logic mode;
    } npb_ctl_t;

    // Per-axis classification of the sample against the box
    typedef struct packed {
        logic [NUM_AXES-1:0] below;
        logic [NUM_AXES-1:0] above;
        logic [NUM_AXES-1:0] side_max;
    } npb_flags_t;

endpackage

@@ sv/npb_classify.sv @@
// Stages 1-2: clamp/side classification per axis, then distance to target plane
module npb_classify
    import npb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  npb_ctl_t                        in_ctl,
    input  logic signed [COORD_WIDTH-1:0]   sample [NUM_AXES],
    input  logic        [2*COORD_WIDTH+1:0] radius,
    input  logic signed [COORD_WIDTH-1:0]   box_lo [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]   box_hi [NUM_AXES],
    output npb_ctl_t                        out_ctl,
    output npb_flags_t                      out_flags,
    output logic signed [COORD_WIDTH-1:0]   out_sample [NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]   out_target [NUM_AXES],
    output logic        [COORD_WIDTH:0]     out_mag [NUM_AXES],
    output logic        [2*COORD_WIDTH+1:0] out_radius
);

    localparam int SUM_W = COORD_WIDTH + 1;
    localparam int RAD_W = 2 * COORD_WIDTH + 2;

    // stage 1 combinational
    logic signed [SUM_W-1:0]       pair_sum [NUM_AXES];
    logic signed [SUM_W-1:0]       twice_s  [NUM_AXES];
    logic                          side_hi  [NUM_AXES];
    npb_flags_t                    flags_next;
    logic signed [COORD_WIDTH-1:0] target_next [NUM_AXES];

    // stage 1 registers
    npb_ctl_t                      ctl1_reg;
    npb_flags_t                    flags1_reg;
    logic signed [COORD_WIDTH-1:0] s1_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] t1_reg [NUM_AXES];
    logic        [RAD_W-1:0]       rad1_reg;

    // stage 2 combinational
    logic signed [SUM_W-1:0]       diff_pos [NUM_AXES];
    logic signed [SUM_W-1:0]       diff_neg [NUM_AXES];
    logic        [SUM_W-1:0]       mag_next [NUM_AXES];

    // stage 2 registers
    npb_ctl_t                      ctl2_reg;
    npb_flags_t                    flags2_reg;
    logic signed [COORD_WIDTH-1:0] s2_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] t2_reg [NUM_AXES];
    logic        [SUM_W-1:0]       mag2_reg [NUM_AXES];
    logic        [RAD_W-1:0]       rad2_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pair_sum[a] = SUM_W'(box_lo[a]) + SUM_W'(box_hi[a]);
            twice_s[a]  = $signed({sample[a], 1'b0});
            side_hi[a]  = twice_s[a] > pair_sum[a];
            flags_next.below[a] = sample[a] < box_lo[a];
            flags_next.above[a] = !flags_next.below[a] && (sample[a] > box_hi[a]);
            // degenerate axis (min == max) reports the min face
            flags_next.side_max[a] = side_hi[a] && (box_hi[a] != box_lo[a]);
            if (flags_next.below[a])
            begin
                target_next[a] = box_lo[a];
            end
            else if (flags_next.above[a] || side_hi[a])
            begin
                target_next[a] = box_hi[a];
            end
            else
            begin
                target_next[a] = box_lo[a];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff_pos[a] = SUM_W'(t1_reg[a]) - SUM_W'(s1_reg[a]);
            diff_neg[a] = SUM_W'(s1_reg[a]) - SUM_W'(t1_reg[a]);
            mag_next[a] = diff_pos[a][SUM_W-1] ? $unsigned(diff_neg[a])
                                                : $unsigned(diff_pos[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        flags1_reg <= flags_next;
        rad1_reg   <= radius;
        flags2_reg <= flags1_reg;
        rad2_reg   <= rad1_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            s1_reg[a]   <= sample[a];
            t1_reg[a]   <= target_next[a];
            s2_reg[a]   <= s1_reg[a];
            t2_reg[a]   <= t1_reg[a];
            mag2_reg[a] <= mag_next[a];
        end
    end

    assign out_ctl    = ctl2_reg;
    assign out_flags  = flags2_reg;
    assign out_radius = rad2_reg;
    assign out_sample = s2_reg;
    assign out_target = t2_reg;
    assign out_mag    = mag2_reg;

endmodule

@@ sv/npb_select.sv @@
// Stage 3: pick projection planes and face, form projected point and offsets
module npb_select
    import npb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  npb_ctl_t                        in_ctl,
    input  npb_flags_t                      in_flags,
    input  logic signed [COORD_WIDTH-1:0]   in_sample [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]   in_target [NUM_AXES],
    input  logic        [COORD_WIDTH:0]     in_mag [NUM_AXES],
    input  logic        [2*COORD_WIDTH+1:0] in_radius,
    output npb_ctl_t                        out_ctl,
    output logic signed [COORD_WIDTH-1:0]   out_point [NUM_AXES],
    output logic        [COORD_WIDTH:0]     out_offset [NUM_AXES],
    output logic signed [FACE_WIDTH-1:0]    out_face,
    output logic        [2*COORD_WIDTH+1:0] out_radius
);

    localparam int SUM_W = COORD_WIDTH + 1;
    localparam int RAD_W = 2 * COORD_WIDTH + 2;

    logic [NUM_AXES-1:0] clamped;
    logic                outside;
    logic lt01, lt02, lt12, lt10, lt20, lt21;
    logic [NUM_AXES-1:0] pick_oh;    // face mode: single nearest plane
    logic [NUM_AXES-1:0] far_oh;     // edge mode: last after stable sort
    logic [NUM_AXES-1:0] near_oh;    // edge mode: first after stable sort
    logic [NUM_AXES-1:0] second_oh;  // edge mode: second, sets the face
    logic [NUM_AXES-1:0] face_oh;
    logic [NUM_AXES-1:0] proj;
    logic signed [FACE_WIDTH-1:0] face_next;

    npb_ctl_t                      ctl_reg;
    logic signed [COORD_WIDTH-1:0] point_reg [NUM_AXES];
    logic        [SUM_W-1:0]       offset_reg [NUM_AXES];
    logic signed [FACE_WIDTH-1:0]  face_reg;
    logic        [RAD_W-1:0]       rad_reg;

    assign clamped = in_flags.below | in_flags.above;
    assign outside = |clamped;

    assign lt01 = in_mag[0] < in_mag[1];
    assign lt02 = in_mag[0] < in_mag[2];
    assign lt12 = in_mag[1] < in_mag[2];
    assign lt10 = in_mag[1] < in_mag[0];
    assign lt20 = in_mag[2] < in_mag[0];
    assign lt21 = in_mag[2] < in_mag[1];

    always_comb
    begin
        if (lt01)
        begin
            pick_oh = lt02 ? 3'b001 : 3'b100;
        end
        else
        begin
            pick_oh = lt12 ? 3'b010 : 3'b100;
        end
        // ties rank the lower axis first
        far_oh    = {!lt20 && !lt21, !lt10 && lt21, lt10 && lt20};
        near_oh   = {lt20 && lt21, lt10 && !lt21, !lt10 && !lt20};
        second_oh = ~(far_oh | near_oh);
    end

    always_comb
    begin
        face_next = FACE_MISS;
        proj      = '0;
        face_oh   = '0;
        if (!outside)
        begin
            if (in_ctl.mode)
            begin
                proj    = ~far_oh;
                face_oh = second_oh;
            end
            else
            begin
                proj    = pick_oh;
                face_oh = pick_oh;
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (outside)
            begin
                // last clamped axis wins
                if (clamped[a])
                begin
                    face_next = {1'b0, AXIS_WIDTH'(a), in_flags.above[a]};
                end
            end
            else if (face_oh[a])
            begin
                face_next = {1'b0, AXIS_WIDTH'(a), in_flags.side_max[a]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg <= face_next;
        rad_reg  <= in_radius;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (clamped[a] || proj[a])
            begin
                point_reg[a]  <= in_target[a];
                offset_reg[a] <= in_mag[a];
            end
            else
            begin
                point_reg[a]  <= in_sample[a];
                offset_reg[a] <= '0;
            end
        end
    end

    assign out_ctl    = ctl_reg;
    assign out_point  = point_reg;
    assign out_offset = offset_reg;
    assign out_face   = face_reg;
    assign out_radius = rad_reg;

endmodule

@@ sv/npb_dist.sv @@
// Stages 4-5: squared offsets, then sum, radius test and result registers
module npb_dist
    import npb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  npb_ctl_t                        in_ctl,
    input  logic signed [COORD_WIDTH-1:0]   in_point [NUM_AXES],
    input  logic        [COORD_WIDTH:0]     in_offset [NUM_AXES],
    input  logic signed [FACE_WIDTH-1:0]    in_face,
    input  logic        [2*COORD_WIDTH+1:0] in_radius,
    output logic                            done,
    output logic                            hit,
    output logic signed [COORD_WIDTH-1:0]   near [NUM_AXES],
    output logic signed [FACE_WIDTH-1:0]    face
);

    localparam int SQ_W  = 2 * COORD_WIDTH + 2;
    localparam int DSQ_W = SQ_W + 2;

    npb_ctl_t                      ctl4_reg;
    logic        [SQ_W-1:0]        sq4_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] point4_reg [NUM_AXES];
    logic signed [FACE_WIDTH-1:0]  face4_reg;
    logic        [SQ_W-1:0]        rad4_reg;

    logic [DSQ_W-1:0] dsq;
    logic             hit_next;

    logic                          done_reg;
    logic                          hit_reg;
    logic signed [COORD_WIDTH-1:0] near_reg [NUM_AXES];
    logic signed [FACE_WIDTH-1:0]  face_reg;

    assign dsq = DSQ_W'(sq4_reg[0]) + DSQ_W'(sq4_reg[1]) + DSQ_W'(sq4_reg[2]);
    assign hit_next = dsq <= DSQ_W'(rad4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl4_reg <= in_ctl;
            done_reg <= ctl4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        face4_reg <= in_face;
        rad4_reg  <= in_radius;
        hit_reg   <= hit_next;
        face_reg  <= hit_next ? face4_reg : FACE_MISS;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sq4_reg[a]    <= SQ_W'(in_offset[a]) * SQ_W'(in_offset[a]);
            point4_reg[a] <= in_point[a];
            near_reg[a]   <= point4_reg[a];
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;
    assign near = near_reg;
    assign face = face_reg;

endmodule

@@ sv/nearest_point_on_box.sv @@
// Top level: box registers and the five-stage nearest-point pipeline
//
//  channel   signals                                      handshake
//  -------   ------------------------------------------   ----------------------------
//  query     start, busy, mode, sample_x/y/z, radius_sqr  taken when start && !busy
//  result    done, hit, near_x/y/z, face                  done strobe, one cycle, no hold
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data    written when valid && ready
//
//  One query per cycle, sustained. Results pass through two classify stages, one
//  plane select stage, a multiply stage for the squared offsets and a sum/compare
//  stage feeding the output registers.
//  busy never rises: the pipeline has no backpressure and the receiver cannot stall.
//  Reset clears the valid bits and loads the unit box (min 0.0, max 1.0).
`include "nearest_point_on_box_macros.svh"

module nearest_point_on_box
    import npb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // query transaction
    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic signed [COORD_WIDTH-1:0]   sample_x,
    input  logic signed [COORD_WIDTH-1:0]   sample_y,
    input  logic signed [COORD_WIDTH-1:0]   sample_z,
    input  logic        [2*COORD_WIDTH+1:0] radius_sqr,
    // result transaction
    output logic                            done,
    output logic                            hit,
    output logic signed [COORD_WIDTH-1:0]   near_x,
    output logic signed [COORD_WIDTH-1:0]   near_y,
    output logic signed [COORD_WIDTH-1:0]   near_z,
    output logic signed [FACE_WIDTH-1:0]    face,
    // configuration transaction
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [COORD_WIDTH-1:0]          cfg_data
);

    localparam int PIPE_LATENCY = 5;
    localparam int RAD_W        = 2 * COORD_WIDTH + 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } cfg_reg_t;

    // box corners
    logic signed [COORD_WIDTH-1:0] box_lo_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] box_hi_reg [NUM_AXES];

    logic signed [COORD_WIDTH-1:0] sample_vec [NUM_AXES];
    npb_ctl_t                      in_ctl;

    // classify -> select
    npb_ctl_t                      cls_ctl;
    npb_flags_t                    cls_flags;
    logic signed [COORD_WIDTH-1:0] cls_sample [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] cls_target [NUM_AXES];
    logic        [COORD_WIDTH:0]   cls_mag [NUM_AXES];
    logic        [RAD_W-1:0]       cls_radius;

    // select -> dist
    npb_ctl_t                      sel_ctl;
    logic signed [COORD_WIDTH-1:0] sel_point [NUM_AXES];
    logic        [COORD_WIDTH:0]   sel_offset [NUM_AXES];
    logic signed [FACE_WIDTH-1:0]  sel_face;
    logic        [RAD_W-1:0]       sel_radius;

    logic signed [COORD_WIDTH-1:0] near_vec [NUM_AXES];

    // Fully pipelined: a query is taken every cycle
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign in_ctl.valid = start && !busy;
    assign in_ctl.mode  = mode;

    assign sample_vec[0] = sample_x;
    assign sample_vec[1] = sample_y;
    assign sample_vec[2] = sample_z;

    // Register file; indexes past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= COORD_WIDTH'(BOX_MAX_RESET);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_X: box_lo_reg[0] <= cfg_data;
                REG_MIN_Y: box_lo_reg[1] <= cfg_data;
                REG_MIN_Z: box_lo_reg[2] <= cfg_data;
                REG_MAX_X: box_hi_reg[0] <= cfg_data;
                REG_MAX_Y: box_hi_reg[1] <= cfg_data;
                REG_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stages 1-2: clamp test, near side, distance to the chosen plane
    npb_classify #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (in_ctl),
        .sample     (sample_vec),
        .radius     (radius_sqr),
        .box_lo     (box_lo_reg),
        .box_hi     (box_hi_reg),
        .out_ctl    (cls_ctl),
        .out_flags  (cls_flags),
        .out_sample (cls_sample),
        .out_target (cls_target),
        .out_mag    (cls_mag),
        .out_radius (cls_radius)
    );

    // Stage 3: which planes get projected, and the face code
    npb_select #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (cls_ctl),
        .in_flags   (cls_flags),
        .in_sample  (cls_sample),
        .in_target  (cls_target),
        .in_mag     (cls_mag),
        .in_radius  (cls_radius),
        .out_ctl    (sel_ctl),
        .out_point  (sel_point),
        .out_offset (sel_offset),
        .out_face   (sel_face),
        .out_radius (sel_radius)
    );

    // Stages 4-5: squared distance against radius, result strobe
    npb_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sel_ctl),
        .in_point  (sel_point),
        .in_offset (sel_offset),
        .in_face   (sel_face),
        .in_radius (sel_radius),
        .done      (done),
        .hit       (hit),
        .near      (near_vec),
        .face      (face)
    );

    assign near_x = near_vec[0];
    assign near_y = near_vec[1];
    assign near_z = near_vec[2];

    // Every accepted query raises done after the pipeline delay set by PIPE_LATENCY
    `NPB_ASSERT_DELAY(a_result_latency, start && !busy, PIPE_LATENCY, done, "query lost in pipeline")

    // A miss always reports the miss face code
    `NPB_ASSERT_IMP(a_miss_face, done && !hit, face == FACE_MISS, "miss without miss face")

    // A hit never reports the miss face code
    `NPB_ASSERT_IMP(a_hit_face, done && hit, face != FACE_MISS, "hit with miss face")

endmodule
